[hdl/dcfc_pkg.sv]
package dcfc_pkg;

  // Default width of the running body sum.
  localparam int unsigned SumWidthDef = 24;

  // Width of the decimal checksum value and of the received byte.
  localparam int unsigned RecvWidth = 30;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned CountWidth = 4;

  // Frame delimiter characters.
  localparam logic [ByteWidth-1:0] ChOpen  = 8'h28;
  localparam logic [ByteWidth-1:0] ChClose = 8'h29;
  localparam logic [ByteWidth-1:0] ChEnd   = 8'h2A;
  localparam logic [ByteWidth-1:0] ChZero  = 8'h30;
  localparam logic [ByteWidth-1:0] Radix   = 8'd10;

  // The length field never declares more digits than this.
  localparam logic [CountWidth-1:0] MaxDigits = 4'd9;

  // Position inside a frame.
  typedef enum logic [2:0] {
    PH_MARK  = 3'd0,
    PH_FIRST = 3'd1,
    PH_BODY  = 3'd2,
    PH_LEN   = 3'd3,
    PH_SUM   = 3'd4
  } phase_e;

  // Verdict reported at the end of a frame.
  typedef enum logic [1:0] {
    ST_MATCH     = 2'd0,
    ST_MISMATCH  = 2'd1,
    ST_MALFORMED = 2'd2
  } status_e;

  // Per-byte outcome from the parser to the stream wrapper.
  typedef struct packed {
    logic    emit;
    status_e status;
  } dcfc_res_t;

  // True for the ASCII characters '0' to '9'.
  function automatic logic is_digit(input logic [ByteWidth-1:0] b);
    return (b >= ChZero) && (b < (ChZero + Radix));
  endfunction

endpackage

[hdl/decimal_checksum_frame_checker_unit.sv]
// Decimal checksum frame checker.
// Bytes of a text frame enter on the slave stream, one byte per word in
// s_axis_tdata_i[7:0]. A frame is a marker byte, a body, '(', a length
// field, ')', decimal checksum digits and '*'. Every '*' ends a frame and
// produces one result word on the master stream; no other byte produces one.
// Result word: status (match, mismatch, malformed), the saturating body sum
// and the checksum value read from the frame.
// A byte accepted into the input register is parsed combinationally; an end byte's
// result word is loaded into the result register once the result slot is free, and
// then waits there until the receiver takes it.
// Throughput: one byte per cycle, except while an end byte waits on a pending result,
// set by the single parse stage between the input register and the result register.
// Reset clears the frame state and the valid flags of the input and result registers;
// the next byte is taken as a frame marker.
// While the receiver stalls with a result pending, bytes that do not end a
// frame keep flowing; an end byte waits in the input register and tready
// drops until the pending result is taken.
module decimal_checksum_frame_checker_unit
  import dcfc_pkg::*;
#(
  parameter int unsigned SUM_WIDTH = SumWidthDef,
  localparam int unsigned TdataWidth = ((SUM_WIDTH + RecvWidth + 2 + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [ByteWidth-1:0]  s_axis_tdata_i,   // rx_byte
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [TdataWidth-1:0] m_axis_tdata_o    // status, computed_sum, received_sum
);

  logic                 in_vld_q, in_vld_d;
  logic [ByteWidth-1:0] in_byte_q;
  logic                 out_vld_q, out_vld_d;
  status_e              out_status_q;
  logic [SUM_WIDTH-1:0] out_comp_q;
  logic [RecvWidth-1:0] out_recv_q;

  dcfc_res_t            res;
  logic [SUM_WIDTH-1:0] comp_sum;
  logic [RecvWidth-1:0] recv_sum;
  logic                 out_free;
  logic                 step;
  logic                 load_out;

  // Parse stage.
  dcfc_parser #(
    .SUM_WIDTH(SUM_WIDTH)
  ) u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (step),
    .byte_i         (in_byte_q),
    .res_o          (res),
    .computed_sum_o (comp_sum),
    .received_sum_o (recv_sum)
  );

  // A byte moves on unless it ends a frame and the result slot is busy.
  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign step            = in_vld_q && (!res.emit || out_free);
  assign load_out        = step && res.emit;
  assign s_axis_tready_o = !in_vld_q || step;

  always_comb begin
    in_vld_d = in_vld_q;
    if (s_axis_tready_o) begin
      in_vld_d = s_axis_tvalid_i;
    end
    out_vld_d = out_vld_q;
    if (load_out) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end
  end

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
    if (load_out) begin
      out_status_q <= res.status;
      out_comp_q   <= comp_sum;
      out_recv_q   <= recv_sum;
    end
  end

  // Result word packing, zero filled to whole bytes.
  always_comb begin
    m_axis_tdata_o                                  = '0;
    m_axis_tdata_o[1:0]                             = out_status_q;
    m_axis_tdata_o[SUM_WIDTH+1:2]                   = out_comp_q;
    m_axis_tdata_o[SUM_WIDTH+RecvWidth+1:SUM_WIDTH+2] = out_recv_q;
  end

  assign m_axis_tvalid_o = out_vld_q;

  // A parsed end byte always lands in the result register.
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_vld_q)
    else $error("end byte parsed but no result word pending");

  // A stalled byte stays in the input register unchanged.
  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !step |=> in_vld_q && $stable(in_byte_q))
    else $error("stalled input byte lost or changed");

  // Only an end byte can be held back.
  a_stall_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !step |-> res.emit && out_vld_q && !m_axis_tready_i)
    else $error("input stalled without a pending result");

endmodule

[hdl/dcfc_parser.sv]
module dcfc_parser
  import dcfc_pkg::*;
#(
  parameter int unsigned SUM_WIDTH = SumWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  logic [ByteWidth-1:0]  byte_i,
  output dcfc_res_t             res_o,
  output logic [SUM_WIDTH-1:0]  computed_sum_o,
  output logic [RecvWidth-1:0]  received_sum_o
);

  phase_e                phase_q, phase_d;
  logic [SUM_WIDTH-1:0]  body_sum_q, body_sum_d;
  logic [CountWidth-1:0] declared_q, declared_d;
  logic [RecvWidth-1:0]  digit_value_q, digit_value_d;
  logic [CountWidth-1:0] digits_seen_q, digits_seen_d;

  logic                  is_end;
  logic [SUM_WIDTH:0]    sum_ext;
  logic [SUM_WIDTH-1:0]  sum_sat;
  logic [CountWidth:0]   decl_ext;
  logic [CountWidth-1:0] decl_sat;
  logic [3:0]            digit;
  logic [RecvWidth-1:0]  value_next;

  assign is_end = (byte_i == ChEnd);

  // Saturating add of the byte to the body sum.
  assign sum_ext = {1'b0, body_sum_q} + (SUM_WIDTH+1)'(byte_i);
  assign sum_sat = sum_ext[SUM_WIDTH] ? {SUM_WIDTH{1'b1}} : sum_ext[SUM_WIDTH-1:0];

  // Length field digit, summed and capped at nine.
  assign decl_ext = {1'b0, declared_q} + (CountWidth+1)'(4'(byte_i - ChZero));
  assign decl_sat = (decl_ext > (CountWidth+1)'(MaxDigits)) ? MaxDigits
                                                            : decl_ext[CountWidth-1:0];

  // Checksum digit: a non-digit counts as zero; value times ten by two shifts.
  assign digit      = is_digit(byte_i) ? 4'(byte_i - ChZero) : 4'd0;
  assign value_next = (digit_value_q << 3) + (digit_value_q << 1) + RecvWidth'(digit);

  // Next state.
  always_comb begin
    phase_d       = phase_q;
    body_sum_d    = body_sum_q;
    declared_d    = declared_q;
    digit_value_d = digit_value_q;
    digits_seen_d = digits_seen_q;
    if (fire_i) begin
      if (is_end) begin
        phase_d       = PH_MARK;
        body_sum_d    = '0;
        declared_d    = '0;
        digit_value_d = '0;
        digits_seen_d = '0;
      end else begin
        unique case (phase_q)
          PH_FIRST: begin
            body_sum_d = sum_sat;
            phase_d    = PH_BODY;
          end
          PH_BODY: begin
            if (byte_i == ChOpen) begin
              phase_d = PH_LEN;
            end else begin
              body_sum_d = sum_sat;
            end
          end
          PH_LEN: begin
            if (byte_i == ChClose) begin
              phase_d = PH_SUM;
            end else if (is_digit(byte_i)) begin
              declared_d = decl_sat;
            end
          end
          PH_SUM: begin
            if (digits_seen_q < declared_q) begin
              digit_value_d = value_next;
              digits_seen_d = digits_seen_q + 1'b1;
            end
          end
          default: begin
            phase_d = PH_FIRST;
          end
        endcase
      end
    end
  end

  // Verdict for an end byte, taken from the state before it.
  always_comb begin
    res_o.emit = is_end;
    if ((phase_q != PH_SUM) || (digits_seen_q < declared_q)) begin
      res_o.status = ST_MALFORMED;
    end else if (32'(digit_value_q) == 32'(body_sum_q)) begin
      res_o.status = ST_MATCH;
    end else begin
      res_o.status = ST_MISMATCH;
    end
    computed_sum_o = body_sum_q;
    received_sum_o = digit_value_q;
  end

  // Frame state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_MARK;
      body_sum_q    <= '0;
      declared_q    <= '0;
      digit_value_q <= '0;
      digits_seen_q <= '0;
    end else begin
      phase_q       <= phase_d;
      body_sum_q    <= body_sum_d;
      declared_q    <= declared_d;
      digit_value_q <= digit_value_d;
      digits_seen_q <= digits_seen_d;
    end
  end

  // An end byte always leaves the parser ready for a new frame.
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && is_end |=> (phase_q == PH_MARK) && (body_sum_q == '0) &&
                         (digits_seen_q == '0))
    else $error("frame state not cleared after end byte");

  // The checksum never reads more digits than were declared.
  a_digits_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digits_seen_q <= declared_q)
    else $error("more checksum digits read than declared");

  // The declared digit count is capped.
  a_declared_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    declared_q <= MaxDigits)
    else $error("declared digit count above cap");

  // Checksum digits are only counted in the checksum phase.
  a_digits_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (digits_seen_q != '0) |-> (phase_q == PH_SUM))
    else $error("checksum digits counted outside checksum phase");

endmodule
